FILE: hdl/spv_pkg.sv
// Shared types, constants and codes for the skin pixel palette vote block.
package spv_pkg;

  localparam int PALETTE_DEPTH = 128;
  localparam int VOTE_WIDTH    = 20;
  localparam int IDX_W         = $clog2(PALETTE_DEPTH);
  localparam int N_W           = 8;
  localparam int LOSS_W        = 31;
  localparam int COUNT_W       = 20;
  localparam int DIST_W        = 20;
  localparam int SQ_W          = 21;
  localparam int SQRT_STEPS    = 10;
  localparam int STEP_W        = $clog2(SQRT_STEPS);
  localparam int PAL_W         = 24;

  localparam logic [LOSS_W-1:0]     LOSS_MAX = {LOSS_W{1'b1}};
  localparam logic [VOTE_WIDTH-1:0] VOTE_MAX = {VOTE_WIDTH{1'b1}};
  localparam logic [SQ_W-1:0]       SQRT_TOP = SQ_W'(1) << (2 * (SQRT_STEPS - 1));

  typedef enum logic [2:0] {
    REQ_LOAD   = 3'd0,
    REQ_PIXEL  = 3'd1,
    REQ_READ   = 3'd2,
    REQ_REPORT = 3'd3,
    REQ_CLEAR  = 3'd4
  } req_t;

  typedef enum logic [1:0] {
    KIND_PIXEL  = 2'd0,
    KIND_VOTES  = 2'd1,
    KIND_REPORT = 2'd2
  } kind_t;

  typedef enum logic [2:0] {
    CFG_RED_MIN     = 3'd0,
    CFG_GREEN_MIN   = 3'd1,
    CFG_BLUE_MIN    = 3'd2,
    CFG_RG_GAP      = 3'd3,
    CFG_ENTRIES     = 3'd4,
    CFG_METRIC_MODE = 3'd5
  } cfg_idx_t;

  typedef struct packed {
    logic [2:0] req_type;
    logic [6:0] entry_index;
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
  } in_item_t;

  typedef struct packed {
    logic [1:0]         result_kind;
    logic               skin;
    logic [6:0]         chosen_index;
    logic [COUNT_W-1:0] count;
  } out_item_t;

  typedef struct packed {
    logic [7:0]     red_min;
    logic [7:0]     green_min;
    logic [7:0]     blue_min;
    logic [7:0]     rg_gap;
    logic [N_W-1:0] entries_in_use;
    logic           metric_mode;
  } cfg_t;

  typedef struct packed {
    req_t       req;
    logic [6:0] idx;
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
    logic       skin;
  } job_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_PIX_RD,
    ST_PIX_MUL,
    ST_PIX_WGT,
    ST_PIX_SUM,
    ST_PIX_SQRT,
    ST_PIX_ACC,
    ST_VOTE_RD,
    ST_VOTE_WR,
    ST_RDV_RD,
    ST_RDV_OUT,
    ST_REP_RD,
    ST_REP_CMP,
    ST_EMIT
  } state_t;

endpackage

FILE: hdl/spv_ram.sv
// Generic single write port, single read port RAM with registered read data.
module spv_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

FILE: hdl/spv_front.sv
// Front end: configuration registers, request decode, skin test and job queue.
module spv_front (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  output logic             full,
  input  spv_pkg::in_item_t in_data,
  input  logic             valid,
  output logic             ready,
  input  logic [2:0]       cfg_index,
  input  logic [7:0]       cfg_wdata,
  output spv_pkg::cfg_t    cfg,
  output logic             job_valid,
  input  logic             job_ready,
  output spv_pkg::job_t    job
);
  import spv_pkg::*;

  cfg_t       cfg_r;
  job_t       q_r [2];
  logic       wr_ptr_r;
  logic       rd_ptr_r;
  logic [1:0] cnt_r;
  logic       in_take;
  logic       enq;
  logic       deq;
  logic       code_ok;
  logic       skin;
  logic [7:0] gap;
  job_t       new_job;

  assign ready = 1'b1;
  assign cfg   = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.red_min        <= 8'd95;
      cfg_r.green_min      <= 8'd40;
      cfg_r.blue_min       <= 8'd20;
      cfg_r.rg_gap         <= 8'd15;
      cfg_r.entries_in_use <= N_W'(109);
      cfg_r.metric_mode    <= 1'b1;
    end else if (valid) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_RED_MIN:     cfg_r.red_min        <= cfg_wdata;
        CFG_GREEN_MIN:   cfg_r.green_min      <= cfg_wdata;
        CFG_BLUE_MIN:    cfg_r.blue_min       <= cfg_wdata;
        CFG_RG_GAP:      cfg_r.rg_gap         <= cfg_wdata;
        CFG_ENTRIES:     cfg_r.entries_in_use <= cfg_wdata;
        CFG_METRIC_MODE: cfg_r.metric_mode    <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    gap  = (in_data.red > in_data.green) ? in_data.red - in_data.green
                                          : in_data.green - in_data.red;
    skin = (in_data.red > cfg_r.red_min) && (in_data.green > cfg_r.green_min) &&
           (in_data.blue > cfg_r.blue_min) && (in_data.red > in_data.blue) &&
           (in_data.red > in_data.green) && (gap > cfg_r.rg_gap);
    unique case (in_data.req_type)
      REQ_LOAD, REQ_PIXEL, REQ_READ, REQ_REPORT, REQ_CLEAR: code_ok = 1'b1;
      default: code_ok = 1'b0;
    endcase
    new_job.req   = req_t'(in_data.req_type);
    new_job.idx   = in_data.entry_index;
    new_job.blue  = in_data.blue;
    new_job.green = in_data.green;
    new_job.red   = in_data.red;
    new_job.skin  = skin;
  end

  assign full      = (cnt_r == 2'd2);
  assign in_take   = push && !full;
  assign enq       = in_take && code_ok;
  assign job_valid = (cnt_r != 2'd0);
  assign deq       = job_valid && job_ready;
  assign job       = q_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (enq) begin
      q_r[wr_ptr_r] <= new_job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (enq) begin
        wr_ptr_r <= !wr_ptr_r;
      end
      if (deq) begin
        rd_ptr_r <= !rd_ptr_r;
      end
      cnt_r <= cnt_r + {1'b0, enq} - {1'b0, deq};
    end
  end

endmodule

FILE: hdl/spv_back.sv
// Back end: palette, loss and vote stores with the sequencer that walks them.
module spv_back (
  input  logic               clk,
  input  logic               rst_n,
  input  spv_pkg::cfg_t      cfg,
  input  logic               job_valid,
  output logic               job_ready,
  input  spv_pkg::job_t      job,
  output logic               empty,
  input  logic               pop,
  output spv_pkg::out_item_t out_data
);
  import spv_pkg::*;

  state_t                   state_r, state_nxt;
  job_t                     job_r;
  logic [IDX_W-1:0]         i_r;
  logic [LOSS_W-1:0]        best_r;
  logic [IDX_W-1:0]         pick_r;
  logic [IDX_W-1:0]         last_r;
  logic [PALETTE_DEPTH-1:0] loss_vld_r;
  logic [PALETTE_DEPTH-1:0] vote_vld_r;
  logic [VOTE_WIDTH-1:0]    most_r;
  logic [IDX_W-1:0]         win_r;
  logic [15:0]              sqr_r, sqg_r, sqb_r;
  logic [9:0]               wr_r, wb_r;
  logic [25:0]              prr_r, prb_r;
  logic [DIST_W-1:0]        dist_r;
  logic [SQ_W-1:0]          sq_v_r, sq_res_r, sq_bit_r;
  logic [STEP_W-1:0]        step_r;
  out_item_t                res_r;
  out_item_t                out_r;
  logic                     out_valid_r;

  logic [N_W-1:0]    n_act;
  logic [IDX_W-1:0]  last_idx;
  logic              is_last;
  logic              emit_go;
  logic              pal_we, pal_re, loss_we, loss_re, vote_we, vote_re;
  logic [IDX_W-1:0]  vote_raddr;
  logic [PAL_W-1:0]  pal_rdata;
  logic [LOSS_W-1:0] loss_rdata, loss_val, t_sat;
  logic [VOTE_WIDTH-1:0] vote_rdata, vote_val, vote_inc;
  logic [31:0]       lsum;
  logic [7:0]        pb, pg, pr, db, dg, dr;
  logic [8:0]        msum;
  logic [DIST_W-1:0] vsum;
  logic [SQ_W-1:0]   trial, sq_v_nxt, sq_res_nxt;
  logic              better;
  logic              vote_better;

  always_comb begin
    n_act = cfg.entries_in_use;
    if (n_act == '0) begin
      n_act = N_W'(1);
    end else if (n_act > N_W'(PALETTE_DEPTH)) begin
      n_act = N_W'(PALETTE_DEPTH);
    end
    last_idx = IDX_W'(n_act - N_W'(1));
  end

  assign is_last   = (i_r == last_idx);
  assign job_ready = (state_r == ST_IDLE);
  assign emit_go   = (state_r == ST_EMIT) && (!out_valid_r || pop);

  always_comb begin
    pb       = pal_rdata[7:0];
    pg       = pal_rdata[15:8];
    pr       = pal_rdata[23:16];
    db       = (job_r.blue > pb) ? job_r.blue - pb : pb - job_r.blue;
    dg       = (job_r.green > pg) ? job_r.green - pg : pg - job_r.green;
    dr       = (job_r.red > pr) ? job_r.red - pr : pr - job_r.red;
    msum     = ({1'b0, job_r.red} + {1'b0, pr}) >> 1;
    if (cfg.metric_mode) begin
      vsum = DIST_W'(prr_r >> 8) + DIST_W'({sqg_r, 2'b00}) + DIST_W'(prb_r >> 8);
    end else begin
      vsum = DIST_W'(sqr_r) + DIST_W'(sqg_r) + DIST_W'(sqb_r);
    end
    trial = sq_res_r + sq_bit_r;
    if (sq_v_r >= trial) begin
      sq_v_nxt   = sq_v_r - trial;
      sq_res_nxt = (sq_res_r >> 1) + sq_bit_r;
    end else begin
      sq_v_nxt   = sq_v_r;
      sq_res_nxt = sq_res_r >> 1;
    end
    loss_val = loss_vld_r[i_r] ? loss_rdata : '0;
    lsum     = {1'b0, loss_val} + 32'(dist_r);
    t_sat    = (lsum > 32'(LOSS_MAX)) ? LOSS_MAX : lsum[LOSS_W-1:0];
    better   = (t_sat < best_r);
    vote_val = (state_r == ST_VOTE_WR) ? (vote_vld_r[pick_r] ? vote_rdata : '0)
             : (state_r == ST_RDV_OUT) ? (vote_vld_r[job_r.idx] ? vote_rdata : '0)
             : (vote_vld_r[i_r] ? vote_rdata : '0);
    vote_inc    = (vote_val < VOTE_MAX) ? vote_val + VOTE_WIDTH'(1) : vote_val;
    vote_better = (vote_val > most_r);
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (job_valid) begin
          unique case (job.req)
            REQ_PIXEL:  state_nxt = job.skin ? ST_PIX_RD : ST_EMIT;
            REQ_READ:   state_nxt = ST_RDV_RD;
            REQ_REPORT: state_nxt = ST_REP_RD;
            default:    state_nxt = ST_IDLE;
          endcase
        end
      end
      ST_PIX_RD:   state_nxt = ST_PIX_MUL;
      ST_PIX_MUL:  state_nxt = ST_PIX_WGT;
      ST_PIX_WGT:  state_nxt = ST_PIX_SUM;
      ST_PIX_SUM:  state_nxt = cfg.metric_mode ? ST_PIX_SQRT : ST_PIX_ACC;
      ST_PIX_SQRT: state_nxt = (step_r == STEP_W'(SQRT_STEPS - 1)) ? ST_PIX_ACC : ST_PIX_SQRT;
      ST_PIX_ACC:  state_nxt = is_last ? ST_VOTE_RD : ST_PIX_RD;
      ST_VOTE_RD:  state_nxt = ST_VOTE_WR;
      ST_VOTE_WR:  state_nxt = ST_EMIT;
      ST_RDV_RD:   state_nxt = ST_RDV_OUT;
      ST_RDV_OUT:  state_nxt = ST_EMIT;
      ST_REP_RD:   state_nxt = ST_REP_CMP;
      ST_REP_CMP:  state_nxt = is_last ? ST_EMIT : ST_REP_RD;
      ST_EMIT:     state_nxt = emit_go ? ST_IDLE : ST_EMIT;
      default:     state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    pal_we     = 1'b0;
    pal_re     = 1'b0;
    loss_we    = 1'b0;
    loss_re    = 1'b0;
    vote_we    = 1'b0;
    vote_re    = 1'b0;
    vote_raddr = i_r;
    unique case (state_r)
      ST_IDLE:    pal_we = job_valid && (job.req == REQ_LOAD);
      ST_PIX_RD: begin
        pal_re  = 1'b1;
        loss_re = 1'b1;
      end
      ST_PIX_ACC: loss_we = 1'b1;
      ST_VOTE_RD: begin
        vote_re    = 1'b1;
        vote_raddr = pick_r;
      end
      ST_VOTE_WR: vote_we = 1'b1;
      ST_RDV_RD: begin
        vote_re    = 1'b1;
        vote_raddr = job_r.idx;
      end
      ST_REP_RD:  vote_re = 1'b1;
      default: ;
    endcase
  end

  spv_ram #(.WIDTH(PAL_W), .DEPTH(PALETTE_DEPTH)) u_pal (
    .clk   (clk),
    .we    (pal_we),
    .waddr (job.idx),
    .wdata ({job.red, job.green, job.blue}),
    .re    (pal_re),
    .raddr (i_r),
    .rdata (pal_rdata)
  );

  spv_ram #(.WIDTH(LOSS_W), .DEPTH(PALETTE_DEPTH)) u_loss (
    .clk   (clk),
    .we    (loss_we),
    .waddr (i_r),
    .wdata (t_sat),
    .re    (loss_re),
    .raddr (i_r),
    .rdata (loss_rdata)
  );

  spv_ram #(.WIDTH(VOTE_WIDTH), .DEPTH(PALETTE_DEPTH)) u_vote (
    .clk   (clk),
    .we    (vote_we),
    .waddr (pick_r),
    .wdata (vote_inc),
    .re    (vote_re),
    .raddr (vote_raddr),
    .rdata (vote_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      loss_vld_r  <= '0;
      vote_vld_r  <= '0;
      last_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == ST_IDLE && job_valid && job.req == REQ_CLEAR) begin
        loss_vld_r <= '0;
        vote_vld_r <= '0;
        last_r     <= '0;
      end
      if (state_r == ST_PIX_ACC) begin
        loss_vld_r[i_r] <= 1'b1;
      end
      if (state_r == ST_VOTE_RD) begin
        last_r <= pick_r;
      end
      if (state_r == ST_VOTE_WR) begin
        vote_vld_r[pick_r] <= 1'b1;
      end
      if (emit_go) begin
        out_valid_r <= 1'b1;
      end else if (pop) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit_go) begin
      out_r <= res_r;
    end
    case (state_r)
      ST_IDLE: begin
        job_r  <= job;
        i_r    <= '0;
        best_r <= LOSS_MAX;
        pick_r <= last_r;
        most_r <= '0;
        win_r  <= '0;
        res_r  <= '{result_kind: KIND_PIXEL, skin: 1'b0, chosen_index: '0, count: '0};
      end
      ST_PIX_MUL: begin
        sqr_r <= dr * dr;
        sqg_r <= dg * dg;
        sqb_r <= db * db;
        wr_r  <= 10'd512 + 10'(msum);
        wb_r  <= 10'd767 - 10'(msum);
      end
      ST_PIX_WGT: begin
        prr_r <= wr_r * sqr_r;
        prb_r <= wb_r * sqb_r;
      end
      ST_PIX_SUM: begin
        dist_r   <= vsum;
        sq_v_r   <= SQ_W'(vsum);
        sq_res_r <= '0;
        sq_bit_r <= SQRT_TOP;
        step_r   <= '0;
      end
      ST_PIX_SQRT: begin
        sq_v_r   <= sq_v_nxt;
        sq_res_r <= sq_res_nxt;
        sq_bit_r <= sq_bit_r >> 2;
        step_r   <= step_r + STEP_W'(1);
        dist_r   <= DIST_W'(sq_res_nxt);
      end
      ST_PIX_ACC: begin
        if (better) begin
          best_r <= t_sat;
          pick_r <= i_r;
        end
        i_r <= i_r + IDX_W'(1);
      end
      ST_VOTE_WR: begin
        res_r <= '{result_kind: KIND_PIXEL, skin: 1'b1, chosen_index: 7'(pick_r), count: '0};
      end
      ST_RDV_OUT: begin
        res_r <= '{result_kind: KIND_VOTES, skin: 1'b0, chosen_index: job_r.idx,
                   count: COUNT_W'(vote_val)};
      end
      ST_REP_CMP: begin
        if (vote_better) begin
          most_r <= vote_val;
          win_r  <= i_r;
          res_r  <= '{result_kind: KIND_REPORT, skin: 1'b0, chosen_index: 7'(i_r),
                     count: COUNT_W'(vote_val)};
        end else begin
          res_r  <= '{result_kind: KIND_REPORT, skin: 1'b0, chosen_index: 7'(win_r),
                     count: COUNT_W'(most_r)};
        end
        i_r <= i_r + IDX_W'(1);
      end
      default: ;
    endcase
  end

  assign empty    = !out_valid_r;
  assign out_data = out_r;

endmodule

FILE: hdl/skin_pixel_palette_vote.sv
// Top level of the skin pixel palette vote block.
//
//   channel  | handshake        | payload
//   ---------+------------------+-----------------------------
//   input    | push / full      | in_data (request item)
//   result   | empty / pop      | out_data (result item)
//   config   | valid / ready    | cfg_index, cfg_wdata
//
// A skin pixel walks all entries in use through read, multiply, weight, sum
// and accumulate steps (plus square-root steps with the redmean metric), then
// reads and writes the chosen vote. A report reads and compares each entry in
// use; loads, clears, vote reads and non-skin pixels walk no entries. Queued
// jobs start only when idle. No clearing pass follows reset; a two-entry job
// queue and output register let input and result sides stall independently.
module skin_pixel_palette_vote (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  output logic               full,
  input  spv_pkg::in_item_t  in_data,
  output logic               empty,
  input  logic               pop,
  output spv_pkg::out_item_t out_data,
  input  logic               valid,
  output logic               ready,
  input  logic [2:0]         cfg_index,
  input  logic [7:0]         cfg_wdata
);
  import spv_pkg::*;

  cfg_t cfg;
  job_t job;
  logic job_valid;
  logic job_ready;

  spv_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .full      (full),
    .in_data   (in_data),
    .valid     (valid),
    .ready     (ready),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg),
    .job_valid (job_valid),
    .job_ready (job_ready),
    .job       (job)
  );

  spv_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .job_valid (job_valid),
    .job_ready (job_ready),
    .job       (job),
    .empty     (empty),
    .pop       (pop),
    .out_data  (out_data)
  );

endmodule

FILE: hdl/spv_checker.sv
// Port-level checker for the skin pixel palette vote block, with its bind.
module spv_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               full,
  input logic               empty,
  input logic               pop,
  input spv_pkg::out_item_t out_data
);
  import spv_pkg::*;

  a_reset_empty: assert property (@(posedge clk) !rst_n |=> empty && !full)
    else $error("Queues are not empty after reset.");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !empty && !pop |=> !empty && $stable(out_data))
    else $error("Waiting result changed before its transfer.");

  a_kind: assert property (@(posedge clk) disable iff (!rst_n)
    !empty |-> out_data.result_kind != 2'd3)
    else $error("Result kind is out of range.");

  a_skin: assert property (@(posedge clk) disable iff (!rst_n)
    !empty && out_data.skin |-> out_data.result_kind == KIND_PIXEL &&
      out_data.count == '0)
    else $error("Skin flag set on a result that is not a plain pixel result.");

endmodule

bind skin_pixel_palette_vote spv_checker u_spv_checker (
  .clk      (clk),
  .rst_n    (rst_n),
  .full     (full),
  .empty    (empty),
  .pop      (pop),
  .out_data (out_data)
);

FILE: verif/skin_pixel_palette_vote_test.sv
// Self-checking testbench for skin_pixel_palette_vote with a scoreboard-based predictor.
module skin_pixel_palette_vote_test;
  import spv_pkg::*;

  class vote_scoreboard;
    bit [7:0]        red_min, green_min, blue_min, rg_gap, entries;
    bit              mode;
    bit [23:0]       palette [PALETTE_DEPTH];
    longint unsigned loss [PALETTE_DEPTH];
    int unsigned     votes [PALETTE_DEPTH];
    bit [6:0]        last_pick;
    out_item_t       pending_q [$];
    int              errors;

    function new();
      red_min = 95; green_min = 40; blue_min = 20; rg_gap = 15;
      entries = 109; mode = 1'b1; last_pick = '0; errors = 0;
      foreach (palette[i]) begin
        palette[i] = '0; loss[i] = 0; votes[i] = 0;
      end
    endfunction

    function void write_reg(cfg_idx_t idx, bit [7:0] v);
      case (idx)
        CFG_RED_MIN:     red_min = v;
        CFG_GREEN_MIN:   green_min = v;
        CFG_BLUE_MIN:    blue_min = v;
        CFG_RG_GAP:      rg_gap = v;
        CFG_ENTRIES:     entries = v;
        CFG_METRIC_MODE: mode = v[0];
        default: ;
      endcase
    endfunction

    function int unsigned active_count();
      if (entries == 0) return 1;
      if (entries > PALETTE_DEPTH) return PALETTE_DEPTH;
      return entries;
    endfunction

    function int unsigned int_sqrt(int unsigned v);
      int unsigned res, t;
      res = 0;
      for (int b = 15; b >= 0; b--) begin
        t = res | (32'd1 << b);
        if (t * t <= v) res = t;
      end
      return res;
    endfunction

    function int unsigned color_distance(bit [7:0] b, bit [7:0] g, bit [7:0] r,
                                         bit [23:0] e);
      int unsigned pb, pg, pr, db, dg, dr, m, v;
      pb = e[7:0]; pg = e[15:8]; pr = e[23:16];
      db = (b > pb) ? b - pb : pb - b;
      dg = (g > pg) ? g - pg : pg - g;
      dr = (r > pr) ? r - pr : pr - r;
      if (!mode) return dr * dr + dg * dg + db * db;
      m = (r + pr) >> 1;
      v = (((512 + m) * dr * dr) >> 8) + 4 * dg * dg + (((767 - m) * db * db) >> 8);
      return int_sqrt(v);
    endfunction

    function int pending();
      return pending_q.size();
    endfunction

    function void add_expected(out_item_t res);
      pending_q.insert(pending_q.size(), res);
    endfunction

    function void note_input(in_item_t it);
      out_item_t       res;
      int unsigned     n, gap, most, win;
      longint unsigned best, t;
      bit              skin;
      n = active_count();
      res = '0;
      case (it.req_type)
        REQ_LOAD: palette[it.entry_index] = {it.red, it.green, it.blue};
        REQ_PIXEL: begin
          gap = (it.red > it.green) ? it.red - it.green : it.green - it.red;
          skin = it.red > red_min && it.green > green_min && it.blue > blue_min &&
                 it.red > it.blue && it.red > it.green && gap > rg_gap;
          res.result_kind = KIND_PIXEL;
          if (skin) begin
            for (int i = 0; i < n; i++) begin
              t = loss[i] + color_distance(it.blue, it.green, it.red, palette[i]);
              loss[i] = (t > LOSS_MAX) ? LOSS_MAX : t;
            end
            best = LOSS_MAX;
            for (int i = 0; i < n; i++) begin
              if (loss[i] < best) begin
                best = loss[i];
                last_pick = 7'(i);
              end
            end
            if (votes[last_pick] < VOTE_MAX) votes[last_pick]++;
            res.skin = 1'b1;
            res.chosen_index = last_pick;
          end
          add_expected(res);
        end
        REQ_READ: begin
          res.result_kind = KIND_VOTES;
          res.chosen_index = it.entry_index;
          res.count = COUNT_W'(votes[it.entry_index]);
          add_expected(res);
        end
        REQ_REPORT: begin
          most = 0; win = 0;
          for (int i = 0; i < n; i++) begin
            if (votes[i] > most) begin
              most = votes[i];
              win = i;
            end
          end
          res.result_kind = KIND_REPORT;
          res.chosen_index = 7'(win);
          res.count = COUNT_W'(most);
          add_expected(res);
        end
        REQ_CLEAR: begin
          foreach (loss[i]) begin
            loss[i] = 0; votes[i] = 0;
          end
          last_pick = '0;
        end
        default: ;
      endcase
    endfunction

    function void check(out_item_t got);
      out_item_t want;
      if (pending_q.size() == 0) begin
        $error("result with nothing pending: %h", got);
        errors++;
        return;
      end
      want = pending_q.pop_front();
      if (got.result_kind !== want.result_kind) begin
        $error("result_kind expected %0d actual %0d", want.result_kind, got.result_kind);
        errors++;
      end
      if (got.skin !== want.skin) begin
        $error("skin expected %0d actual %0d", want.skin, got.skin);
        errors++;
      end
      if (got.chosen_index !== want.chosen_index) begin
        $error("chosen_index expected %0d actual %0d", want.chosen_index, got.chosen_index);
        errors++;
      end
      if (got.count !== want.count) begin
        $error("count expected %0d actual %0d", want.count, got.count);
        errors++;
      end
    endfunction
  endclass

  logic      clk, rst_n, push, full, empty, pop, valid, ready;
  in_item_t  in_data;
  out_item_t out_data;
  logic [2:0] cfg_index;
  logic [7:0] cfg_wdata;

  vote_scoreboard sb;
  bit calm, hold_req;
  int idle_cycles;

  skin_pixel_palette_vote dut (
    .clk(clk), .rst_n(rst_n), .push(push), .full(full), .in_data(in_data),
    .empty(empty), .pop(pop), .out_data(out_data), .valid(valid), .ready(ready),
    .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  task automatic send_request(in_item_t it);
    if (!calm && $urandom_range(0, 3) == 0) begin
      push <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    push <= 1'b1;
    in_data <= it;
    do @(posedge clk); while (full);
    sb.note_input(it);
  endtask

  task automatic end_requests();
    push <= 1'b0;
  endtask

  task automatic write_reg(cfg_idx_t idx, bit [7:0] v);
    valid <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= v;
    do @(posedge clk); while (!ready);
    valid <= 1'b0;
    sb.write_reg(idx, v);
  endtask

  task automatic drain();
    end_requests();
    while (sb.pending() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
  endtask

  function automatic in_item_t make_req(bit [2:0] rq, bit [6:0] idx, bit [7:0] b,
                                        bit [7:0] g, bit [7:0] r);
    in_item_t it;
    it.req_type = rq; it.entry_index = idx; it.blue = b; it.green = g; it.red = r;
    return it;
  endfunction

  function automatic in_item_t random_request();
    in_item_t    it;
    int unsigned sel, r, lo;
    it = in_item_t'(34'({$urandom, $urandom}));
    sel = $urandom_range(0, 99);
    if (sel < 60) begin
      it.req_type = REQ_PIXEL;
      if (sel < 40) begin
        lo = (sb.red_min < 255) ? sb.red_min + 1 : 255;
        r = $urandom_range(255, lo);
        lo = (sb.green_min < 255) ? sb.green_min + 1 : 255;
        it.green = 8'($urandom_range(r, lo));
        lo = (sb.blue_min < 255) ? sb.blue_min + 1 : 255;
        it.blue = 8'($urandom_range(r, lo));
        it.red = 8'(r);
      end
    end else if (sel < 72) it.req_type = REQ_LOAD;
    else if (sel < 88) it.req_type = REQ_READ;
    else if (sel < 94) it.req_type = REQ_REPORT;
    else if (sel < 96) it.req_type = REQ_CLEAR;
    else it.req_type = 3'($urandom_range(5, 7));
    return it;
  endfunction

  task automatic random_phase(int count);
    for (int i = 0; i < count; i++) send_request(random_request());
    drain();
  endtask

  initial begin
    pop = 1'b0;
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        pop <= 1'b0;
        repeat (400) @(posedge clk);
      end else if (!calm && $urandom_range(0, 3) == 0) begin
        pop <= 1'b0;
        repeat ($urandom_range(1, 4)) @(posedge clk);
      end
      pop <= 1'b1;
      @(posedge clk);
      if (rst_n && !empty) sb.check(out_data);
    end
  end

  initial begin
    idle_cycles = 0;
    forever begin
      @(posedge clk);
      if ((push && !full) || (pop && !empty) || (valid && ready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= 30000) begin
        $display("status: fail");
        $finish;
      end
    end
  end

  initial begin
    sb = new();
    calm = 1'b0;
    hold_req = 1'b0;
    rst_n = 1'b0;
    push = 1'b0;
    valid = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    in_data = '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    for (int i = 0; i < PALETTE_DEPTH; i++)
      send_request(make_req(REQ_LOAD, 7'(i), 8'($urandom), 8'($urandom), 8'($urandom)));
    send_request(make_req(REQ_LOAD, 7'd127, 8'hFF, 8'hFF, 8'hFF));
    send_request(make_req(REQ_LOAD, 7'd0, 8'h00, 8'h00, 8'h00));
    send_request(make_req(REQ_REPORT, 0, 0, 0, 0));
    send_request(make_req(REQ_PIXEL, 0, 8'd0, 8'd0, 8'd0));
    send_request(make_req(REQ_PIXEL, 0, 8'd255, 8'd255, 8'd255));
    send_request(make_req(REQ_PIXEL, 0, 8'd21, 8'd41, 8'd255));
    send_request(make_req(REQ_PIXEL, 7'd127, 8'd60, 8'd100, 8'd115));
    send_request(make_req(REQ_PIXEL, 0, 8'd60, 8'd100, 8'd116));
    send_request(make_req(REQ_PIXEL, 0, 8'd20, 8'd100, 8'd200));
    send_request(make_req(REQ_PIXEL, 0, 8'd200, 8'd100, 8'd200));
    send_request(make_req(REQ_READ, 7'd0, 0, 0, 0));
    send_request(make_req(REQ_READ, 7'd127, 0, 0, 0));
    send_request(make_req(REQ_REPORT, 0, 0, 0, 0));
    send_request(make_req(3'd5, 0, 0, 0, 0));
    send_request(make_req(3'd6, 0, 0, 0, 0));
    send_request(make_req(3'd7, 7'd127, 8'hFF, 8'hFF, 8'hFF));
    send_request(make_req(REQ_CLEAR, 0, 0, 0, 0));
    send_request(make_req(REQ_REPORT, 0, 0, 0, 0));
    send_request(make_req(REQ_READ, 7'd5, 0, 0, 0));
    send_request(make_req(REQ_PIXEL, 0, 8'd21, 8'd41, 8'd255));
    drain();

    write_reg(CFG_RED_MIN, 8'd0);
    write_reg(CFG_GREEN_MIN, 8'd0);
    write_reg(CFG_BLUE_MIN, 8'd0);
    write_reg(CFG_RG_GAP, 8'd0);
    write_reg(CFG_ENTRIES, 8'd0);
    write_reg(CFG_METRIC_MODE, 8'hFE);
    random_phase(150);

    write_reg(CFG_ENTRIES, 8'd4);
    write_reg(CFG_METRIC_MODE, 8'h01);
    hold_req = 1'b1;
    for (int i = 0; i < 12; i++)
      send_request(make_req(REQ_READ, 7'($urandom), 8'($urandom), 8'($urandom),
                            8'($urandom)));
    random_phase(200);

    write_reg(CFG_RED_MIN, 8'd255);
    write_reg(CFG_GREEN_MIN, 8'd255);
    write_reg(CFG_BLUE_MIN, 8'd255);
    write_reg(CFG_RG_GAP, 8'd255);
    write_reg(CFG_ENTRIES, 8'd200);
    random_phase(40);

    write_reg(CFG_RED_MIN, 8'd95);
    write_reg(CFG_GREEN_MIN, 8'd40);
    write_reg(CFG_BLUE_MIN, 8'd20);
    write_reg(CFG_RG_GAP, 8'd15);
    write_reg(CFG_ENTRIES, 8'd128);
    write_reg(CFG_METRIC_MODE, 8'h00);
    random_phase(25);
    write_reg(CFG_METRIC_MODE, 8'h01);
    random_phase(15);

    for (int p = 0; p < 4; p++) begin
      write_reg(CFG_RED_MIN, 8'($urandom_range(0, 120)));
      write_reg(CFG_GREEN_MIN, 8'($urandom_range(0, 60)));
      write_reg(CFG_BLUE_MIN, 8'($urandom_range(0, 40)));
      write_reg(CFG_RG_GAP, 8'($urandom_range(0, 30)));
      write_reg(CFG_ENTRIES, 8'($urandom_range(1, 8)));
      write_reg(CFG_METRIC_MODE, 8'($urandom));
      if (p == 3) calm = 1'b1;
      random_phase(150);
    end

    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

FILE: files.f
hdl/spv_pkg.sv
hdl/spv_ram.sv
hdl/spv_front.sv
hdl/spv_back.sv
hdl/skin_pixel_palette_vote.sv
hdl/spv_checker.sv
verif/skin_pixel_palette_vote_test.sv
